### rtl/gfau_pkg.sv
// shared types and constants of the binary extension field arithmetic unit
`default_nettype none

package gfau_pkg;

   // defaults of the top-level parameters
   localparam int FIELD_DEGREE_DEFAULT  = 16;
   localparam int EXPONENT_BITS_DEFAULT = 32;

   // reduction polynomial after reset, x^8+x^4+x^3+x+1
   localparam logic [31:0] MODULUS_RESET = 32'd283;

   // operation codes
   typedef enum logic [1:0] {
      ACTION_MULTIPLY   = 2'd0,
      ACTION_POWER      = 2'd1,
      ACTION_RECIPROCAL = 2'd2,
      ACTION_DIVIDE     = 2'd3
   } action_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_UNREDUCED   = 2'd1,
      STATUS_SMALL_MOD   = 2'd2
   } status_type;

   // request word
   typedef struct packed {
      action_type  action;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [31:0] exponent;
   } req_type;

   // response word
   typedef struct packed {
      logic [15:0] result;
      status_type  status;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/gfau_serial_mul.sv
// bit-serial shift-and-xor multiplier modulo a binary polynomial
`default_nettype none

module gfau_serial_mul #(
   parameter int FIELD_DEGREE = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   input  wire logic [FIELD_DEGREE-1:0]                 op_a,
   input  wire logic [FIELD_DEGREE-1:0]                 op_b,
   input  wire logic [FIELD_DEGREE:0]                   modulus,
   input  wire logic [$clog2(FIELD_DEGREE+1)-1:0]       degree,
   output logic                                         busy,
   output logic [FIELD_DEGREE-1:0]                      product
);

   localparam int N = FIELD_DEGREE;

   logic [N-1:0] acc_ff, acc_in;
   logic [N-1:0] shift_ff, shift_in;
   logic [N-1:0] mult_ff, mult_in;
   logic [N:0]   doubled;

   // runs until every set bit of the multiplier has been consumed
   assign busy    = (mult_ff != '0);
   assign product = acc_ff;

   // one multiplier bit per cycle, multiplicand doubled and reduced
   always_comb begin
      doubled = {shift_ff, 1'b0};
      if (doubled[degree]) begin
         doubled = doubled ^ modulus;
      end
      acc_in   = acc_ff;
      shift_in = shift_ff;
      mult_in  = mult_ff;
      if (start) begin
         acc_in   = '0;
         shift_in = op_a;
         mult_in  = op_b;
      end else if (busy) begin
         if (mult_ff[0]) begin
            acc_in = acc_ff ^ shift_ff;
         end
         shift_in = doubled[N-1:0];
         mult_in  = mult_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff <= '0;
      end else begin
         mult_ff <= mult_in;
      end
      acc_ff   <= acc_in;
      shift_ff <= shift_in;
   end

endmodule

`default_nettype wire

### rtl/gf2n_arithmetic_unit.sv
// top level of the binary extension field multiply, power and inverse unit
//
//  channel | direction | handshake           | word
//  req     | in        | req_valid/req_ready | action, operand_a, operand_b, exponent
//  rsp     | out       | rsp_valid/rsp_ready | result, status
//  csr     | in        | csr_valid/csr_ready | reduction polynomial
//
// one word at a time; the bit-serial multipliers set the pace of every action
// after reset and after each csr write the degree is found by a scan from the top
// bit of the modulus down, during which req_ready and csr_ready stay low
// a result held on a stalled rsp channel does not stop the next word being taken
`default_nettype none

module gf2n_arithmetic_unit #(
   parameter int FIELD_DEGREE  = gfau_pkg::FIELD_DEGREE_DEFAULT,
   parameter int EXPONENT_BITS = gfau_pkg::EXPONENT_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire gfau_pkg::req_type     req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output gfau_pkg::rsp_type          rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [FIELD_DEGREE:0] csr_data
);

   import gfau_pkg::*;

   localparam int N  = FIELD_DEGREE;
   localparam int DW = $clog2(FIELD_DEGREE + 1);
   localparam int EW = (EXPONENT_BITS > FIELD_DEGREE) ? EXPONENT_BITS : FIELD_DEGREE;

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_CHECK      = 6'b000010,
      ST_POW_STEP   = 6'b000100,
      ST_POW_WAIT   = 6'b001000,
      ST_FINAL_WAIT = 6'b010000,
      ST_FINISH     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // modulus and degree scan
   logic [N:0]    modulus_ff;
   logic [N:0]    scan_mod_ff;
   logic [DW-1:0] degree_ff;
   logic          scan_ff;

   // latched request
   action_type    act_ff, act_in;
   logic [N-1:0]  opa_ff, opa_in;
   logic [N-1:0]  opb_ff, opb_in;
   logic [EW-1:0] pexp_ff, pexp_in;

   // power loop
   logic [N-1:0]  acc_ff, acc_in;
   logic [N-1:0]  sq_ff, sq_in;
   logic [EW-1:0] e_ff, e_in;
   logic          use_ff, use_in;
   logic [N-1:0]  res_ff, res_in;
   status_type    status_ff, status_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   // multiplier hookup
   logic          mul0_start, mul1_start;
   logic [N-1:0]  mul0_a, mul0_b;
   logic          mul0_busy, mul1_busy;
   logic [N-1:0]  mul0_prod, mul1_prod;

   // derived operand views
   logic [N+15:0]       a_wide, b_wide;
   logic [EW+EXPONENT_BITS-1:0] e_wide;
   logic [N+15:0]       res_wide;
   logic [N-1:0]        high_mask;
   logic [EW-1:0]       recip_exp;
   logic                bad_a, bad_b;

   assign req_ready = (state_ff == ST_IDLE) && !scan_ff;
   assign csr_ready = (state_ff == ST_IDLE) && !scan_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign a_wide   = {{N{1'b0}}, req_data.operand_a};
   assign b_wide   = {{N{1'b0}}, req_data.operand_b};
   assign e_wide   = {{EW{1'b0}}, req_data.exponent[EXPONENT_BITS-1:0]};
   assign res_wide = {16'b0, res_ff};

   // bits at or above the degree, and the exponent 2^n-2 as a thermometer
   always_comb begin
      for (int i = 0; i < N; i++) begin
         high_mask[i] = (32'(i) >= 32'(degree_ff));
      end
      for (int j = 0; j < EW; j++) begin
         recip_exp[j] = (j >= 1) && (32'(j) < 32'(degree_ff));
      end
   end

   assign bad_a = (act_ff != ACTION_RECIPROCAL) && ((opa_ff & high_mask) != '0);
   assign bad_b = (act_ff != ACTION_POWER) && ((opb_ff & high_mask) != '0);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      pexp_in      = pexp_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      e_in         = e_ff;
      use_in       = use_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mul0_start   = 1'b0;
      mul1_start   = 1'b0;
      mul0_a       = acc_ff;
      mul0_b       = sq_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               act_in   = req_data.action;
               opa_in   = a_wide[N-1:0];
               opb_in   = b_wide[N-1:0];
               pexp_in  = e_wide[EW-1:0];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            res_in = '0;
            if (degree_ff < DW'(2)) begin
               status_in = STATUS_SMALL_MOD;
               state_in  = ST_FINISH;
            end else if (bad_a || bad_b) begin
               status_in = STATUS_UNREDUCED;
               state_in  = ST_FINISH;
            end else begin
               status_in = STATUS_OK;
               acc_in    = N'(1);
               unique case (act_ff)
                  ACTION_MULTIPLY: begin
                     mul0_start = 1'b1;
                     mul0_a     = opa_ff;
                     mul0_b     = opb_ff;
                     state_in   = ST_FINAL_WAIT;
                  end
                  ACTION_POWER: begin
                     sq_in    = opa_ff;
                     e_in     = pexp_ff;
                     state_in = ST_POW_STEP;
                  end
                  ACTION_RECIPROCAL, ACTION_DIVIDE: begin
                     sq_in    = opb_ff;
                     e_in     = recip_exp;
                     state_in = ST_POW_STEP;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_POW_STEP: begin
            if (e_ff == '0) begin
               if (act_ff == ACTION_DIVIDE) begin
                  mul0_start = 1'b1;
                  mul0_a     = opa_ff;
                  mul0_b     = acc_ff;
                  state_in   = ST_FINAL_WAIT;
               end else begin
                  res_in   = acc_ff;
                  state_in = ST_FINISH;
               end
            end else begin
               use_in     = e_ff[0];
               mul0_start = e_ff[0];
               mul1_start = 1'b1;
               e_in       = e_ff >> 1;
               state_in   = ST_POW_WAIT;
            end
         end
         ST_POW_WAIT: begin
            if (!mul0_busy && !mul1_busy) begin
               if (use_ff) begin
                  acc_in = mul0_prod;
               end
               sq_in    = mul1_prod;
               state_in = ST_POW_STEP;
            end
         end
         ST_FINAL_WAIT: begin
            if (!mul0_busy) begin
               res_in   = mul0_prod;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.result = res_wide[15:0];
               rsp_data_in.status = status_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers, modulus and degree scan
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MODULUS_RESET[N:0];
         scan_mod_ff  <= MODULUS_RESET[N:0];
         degree_ff    <= DW'(N);
         scan_ff      <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            modulus_ff  <= csr_data;
            scan_mod_ff <= csr_data;
            degree_ff   <= DW'(N);
            scan_ff     <= 1'b1;
         end else if (scan_ff) begin
            if (scan_mod_ff[N] || (degree_ff == '0)) begin
               scan_ff <= 1'b0;
            end else begin
               scan_mod_ff <= scan_mod_ff << 1;
               degree_ff   <= degree_ff - DW'(1);
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      pexp_ff     <= pexp_in;
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      e_ff        <= e_in;
      use_ff      <= use_in;
      res_ff      <= res_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // accumulator times square, and the product of multiply and of the final divide step
   gfau_serial_mul #(
      .FIELD_DEGREE (FIELD_DEGREE)
   ) u_mul0 (
      .clock   (clock),
      .reset   (reset),
      .start   (mul0_start),
      .op_a    (mul0_a),
      .op_b    (mul0_b),
      .modulus (modulus_ff),
      .degree  (degree_ff),
      .busy    (mul0_busy),
      .product (mul0_prod)
   );

   // squaring
   gfau_serial_mul #(
      .FIELD_DEGREE (FIELD_DEGREE)
   ) u_mul1 (
      .clock   (clock),
      .reset   (reset),
      .start   (mul1_start),
      .op_a    (sq_ff),
      .op_b    (sq_ff),
      .modulus (modulus_ff),
      .degree  (degree_ff),
      .busy    (mul1_busy),
      .product (mul1_prod)
   );

endmodule

`default_nettype wire

### tb/gf2n_arithmetic_unit_test.sv
// self-checking testbench of the GF(2^n) multiply, power, reciprocal and divide unit
module gf2n_arithmetic_unit_test;
   import gfau_pkg::*;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   rsp_type       rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   logic [16:0]   csr_data;

   // local copy of the reduction polynomial and the words still owed by the unit
   logic [16:0]   modulus_copy;
   rsp_type       pending_results[$];
   int unsigned   error_count;
   bit            steady;
   bit            req_up;

   gf2n_arithmetic_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // run limit, far beyond the slowest legal run
   initial begin
      #120_000_000;
      $display("gf2n_arithmetic_unit_test: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------- field arithmetic

   // degree of a polynomial, 0 for the constants
   function automatic int unsigned modulus_degree(input logic [16:0] m);
      for (int k = 16; k >= 1; k--)
         if (m[k]) return k;
      return 0;
   endfunction

   // shift-and-xor product of two reduced elements
   function automatic logic [15:0] field_multiply(input logic [15:0] a, input logic [15:0] b,
                                                  input logic [16:0] m, input int unsigned n);
      logic [16:0] acc;
      logic [16:0] t;
      acc = '0;
      t   = {1'b0, a};
      for (int i = 0; i < n; i++) begin
         if (b[i]) acc ^= t;
         t = t << 1;
         if (t[n]) t ^= m;
      end
      return acc[15:0];
   endfunction

   // square-and-multiply, zero exponent gives one
   function automatic logic [15:0] field_power(input logic [15:0] a, input logic [31:0] e,
                                               input logic [16:0] m, input int unsigned n);
      logic [15:0] acc;
      logic [15:0] sq;
      acc = 16'd1;
      sq  = a;
      while (e != 0) begin
         if (e[0]) acc = field_multiply(acc, sq, m, n);
         e  = e >> 1;
         sq = field_multiply(sq, sq, m, n);
      end
      return acc;
   endfunction

   // b^(2^n-2), zero maps to zero
   function automatic logic [15:0] field_reciprocal(input logic [15:0] b, input logic [16:0] m,
                                                    input int unsigned n);
      return field_power(b, (32'd1 << n) - 32'd2, m, n);
   endfunction

   // response word owed for one request word under the current modulus
   function automatic rsp_type predict_word(input req_type w);
      rsp_type     ans;
      int unsigned n;
      bit          use_a;
      bit          use_b;
      ans.result = '0;
      ans.status = STATUS_OK;
      n     = modulus_degree(modulus_copy);
      use_a = (w.action != ACTION_RECIPROCAL);
      use_b = (w.action != ACTION_POWER);
      if (n < 2) begin
         ans.status = STATUS_SMALL_MOD;
      end else if ((use_a && (w.operand_a >> n) != 0) || (use_b && (w.operand_b >> n) != 0)) begin
         ans.status = STATUS_UNREDUCED;
      end else begin
         case (w.action)
            ACTION_MULTIPLY: begin
               ans.result = field_multiply(w.operand_a, w.operand_b, modulus_copy, n);
            end
            ACTION_POWER: begin
               ans.result = field_power(w.operand_a, w.exponent, modulus_copy, n);
            end
            ACTION_RECIPROCAL: begin
               ans.result = field_reciprocal(w.operand_b, modulus_copy, n);
            end
            default: begin
               ans.result = field_multiply(w.operand_a,
                                           field_reciprocal(w.operand_b, modulus_copy, n),
                                           modulus_copy, n);
            end
         endcase
      end
      return ans;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type make_word(input action_type act, input logic [15:0] a,
                                         input logic [15:0] b, input logic [31:0] e);
      req_type w;
      w.action    = act;
      w.operand_a = a;
      w.operand_b = b;
      w.exponent  = e;
      return w;
   endfunction

   // element for degree n: mostly reduced, sometimes a full 16-bit value
   function automatic logic [15:0] random_element(input int unsigned n);
      logic [16:0]  mask;
      int unsigned  r;
      mask = (17'd1 << n) - 17'd1;
      r    = $urandom_range(0, 19);
      if (r < 2) return 16'($urandom);
      if (r == 2) return 16'd0;
      if (r == 3) return mask[15:0];
      return 16'($urandom) & mask[15:0];
   endfunction

   // exponent: mostly small, sometimes full width
   function automatic logic [31:0] random_exponent();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return 32'd0;
      if (r == 1) return 32'hFFFF_FFFF;
      if (r < 6) return $urandom;
      return $urandom_range(0, 40);
   endfunction

   // send one request word and book its response
   task automatic send_word(input req_type w);
      int unsigned gap;
      req_data  <= w;
      req_valid <= 1'b1;
      req_up     = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_word(w));
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         req_up     = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off the sender until every owed word has come back
   task automatic drain_results();
      if (req_up) begin
         req_valid <= 1'b0;
         req_up     = 1'b0;
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write the reduction polynomial once the unit is idle
   task automatic write_modulus(input logic [16:0] m);
      drain_results();
      csr_data  <= m;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      modulus_copy = m;
   endtask

   // ---------------------------------------------------------------- tests

   // field after reset, x^8+x^4+x^3+x+1
   task automatic test_reset_field();
      send_word(make_word(ACTION_MULTIPLY, 16'h0053, 16'h00CA, 32'd0));
      send_word(make_word(ACTION_MULTIPLY, 16'h00FF, 16'h00FF, 32'hFFFF_FFFF));
      send_word(make_word(ACTION_POWER, 16'h0000, 16'h0000, 32'd0));
      send_word(make_word(ACTION_POWER, 16'h0003, 16'hFFFF, 32'hFFFF_FFFF));
      send_word(make_word(ACTION_RECIPROCAL, 16'hFFFF, 16'h0000, 32'd0));
      send_word(make_word(ACTION_RECIPROCAL, 16'h0000, 16'h0001, 32'd0));
      send_word(make_word(ACTION_DIVIDE, 16'h00FF, 16'h0000, 32'd0));
      send_word(make_word(ACTION_DIVIDE, 16'h0000, 16'h0057, 32'd0));
      // unreduced operands that the action uses
      send_word(make_word(ACTION_MULTIPLY, 16'h0100, 16'h0001, 32'd0));
      send_word(make_word(ACTION_RECIPROCAL, 16'h0001, 16'hFFFF, 32'd0));
      send_word(make_word(ACTION_DIVIDE, 16'hFFFF, 16'hFFFF, 32'd0));
   endtask

   // moduli of degree below two, small modulus wins over unreduced operand
   task automatic test_degenerate_moduli();
      write_modulus(17'd0);
      send_word(make_word(ACTION_MULTIPLY, 16'd1, 16'd1, 32'd0));
      send_word(make_word(ACTION_POWER, 16'hFFFF, 16'd0, 32'd0));
      write_modulus(17'd1);
      send_word(make_word(ACTION_RECIPROCAL, 16'd0, 16'd0, 32'd0));
      write_modulus(17'd3);
      send_word(make_word(ACTION_DIVIDE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
   endtask

   // smallest and widest fields, reducible moduli included
   task automatic test_extreme_moduli();
      write_modulus(17'd7);
      send_word(make_word(ACTION_RECIPROCAL, 16'd0, 16'd2, 32'd0));
      send_word(make_word(ACTION_POWER, 16'd2, 16'hFFFF, 32'hFFFF_FFFF));
      send_word(make_word(ACTION_MULTIPLY, 16'd3, 16'd4, 32'd0));
      write_modulus(17'h1100B);
      send_word(make_word(ACTION_MULTIPLY, 16'hFFFF, 16'hFFFF, 32'd0));
      send_word(make_word(ACTION_POWER, 16'hFFFF, 16'd0, 32'hFFFF_FFFF));
      send_word(make_word(ACTION_RECIPROCAL, 16'd0, 16'hFFFF, 32'd0));
      send_word(make_word(ACTION_DIVIDE, 16'h8001, 16'hFFFF, 32'd0));
      write_modulus(17'h1FFFF);
      send_word(make_word(ACTION_DIVIDE, 16'h1234, 16'h8000, 32'd0));
      write_modulus(17'h10000);
      send_word(make_word(ACTION_RECIPROCAL, 16'd0, 16'h0002, 32'd0));
   endtask

   // random words over a series of fields, with one drain mid-phase and one phase without idling
   task automatic test_random_words();
      int unsigned degrees[10];
      int unsigned n;
      logic [16:0] m;
      action_type  act;
      degrees = '{2, 3, 4, 6, 8, 8, 10, 12, 16, 16};
      for (int p = 0; p < 10; p++) begin
         n = degrees[p];
         m = (17'd1 << n) | (17'($urandom) & ((17'd1 << n) - 17'd1));
         if (p == 9) m = 17'($urandom_range(0, 131071));
         write_modulus(m);
         n      = modulus_degree(m);
         steady = (p == 4);
         for (int i = 0; i < 150; i++) begin
            if (p == 2 && i == 75) drain_results();
            act = action_type'($urandom_range(0, 3));
            send_word(make_word(act, random_element(n), random_element(n), random_exponent()));
         end
         steady = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------- response side

   // receiver stalls
   initial begin : rsp_pacing
      int unsigned stall;
      stall     = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0 && !steady) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   // compare each response word with the oldest owed one
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected response word: result %h status %0d",
                        rsp_data.result, rsp_data.status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.result !== want.result || rsp_data.status !== want.status) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected result %h status %0d, got result %h status %0d",
                           want.result, want.status, rsp_data.result, rsp_data.status);
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      modulus_copy = MODULUS_RESET[16:0];
      error_count  = 0;
      steady       = 1'b0;
      req_up       = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_field();
      test_degenerate_moduli();
      test_extreme_moduli();
      test_random_words();

      // wait out the last words and any stray response
      drain_results();
      repeat (700) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("gf2n_arithmetic_unit_test: done, clean");
      end else begin
         $display("gf2n_arithmetic_unit_test: done, errors");
      end
      $finish;
   end

endmodule
